// ===== hdl/tcp_handshake_segment_fsm_assert.svh =====
// Assertion macros for the TCP handshake segment block.
`ifndef TCP_HANDSHAKE_SEGMENT_FSM_ASSERT_SVH
`define TCP_HANDSHAKE_SEGMENT_FSM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define THSF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thsf check failed");

// Next-cycle implication, disabled during reset.
`define THSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thsf check failed");

`endif

// ===== hdl/thsf_pkg.sv =====
// Types, codes and helpers shared by the TCP handshake segment block.
`default_nettype none
package thsf_pkg;

  typedef enum logic [2:0] {
    ST_CLOSED   = 3'd0,
    ST_LISTEN   = 3'd1,
    ST_SYN_SENT = 3'd2,
    ST_SYN_RCVD = 3'd3,
    ST_ESTAB    = 3'd4
  } conn_state_t;

  typedef enum logic [1:0] {
    RP_NONE   = 2'd0,
    RP_RESET  = 2'd1,
    RP_SYNACK = 2'd2,
    RP_ACK    = 2'd3
  } reply_t;

  localparam logic [1:0] CFG_INITIAL_MODE  = 2'd0;
  localparam logic [1:0] CFG_LOCAL_ISS     = 2'd1;
  localparam logic [1:0] CFG_LOCAL_SND_NXT = 2'd2;

  localparam logic [31:0] ISS_START   = 32'd12344;
  localparam logic [31:0] ISS_LIMIT   = 32'hffff_ffff;
  localparam logic [31:0] ISS_RESTART = 32'd12345;

  localparam logic [31:0] LOCAL_SND_NXT_RESET = 32'd1;

  // One received segment header.
  typedef struct packed {
    logic        syn_flag;
    logic        ack_flag;
    logic        rst_flag;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] window;
    logic        child_slot_free;
  } seg_t;

  // Connection context seen by the segment logic.
  typedef struct packed {
    conn_state_t conn_state;
    logic [31:0] iss_counter;
    logic [31:0] send_unacked;
    logic [31:0] local_iss;
    logic [31:0] local_snd_nxt;
  } ctx_t;

  // Context updates produced by one segment.
  typedef struct packed {
    conn_state_t conn_state;
    logic [31:0] iss_counter;
    logic [31:0] send_unacked;
  } upd_t;

  // One result item.
  typedef struct packed {
    reply_t      reply;
    conn_state_t state_now;
    logic        wake_connect;
    logic        child_made;
    logic [31:0] child_iss;
    logic [31:0] child_rcv_nxt;
  } result_t;

  // Map the starting mode to a state; the unused code means closed.
  function automatic conn_state_t mode_to_state(input logic [1:0] mode);
    conn_state_t st;
    case (mode)
      2'd1:    st = ST_LISTEN;
      2'd2:    st = ST_SYN_SENT;
      default: st = ST_CLOSED;
    endcase
    return st;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/thsf_seg_logic.sv =====
// Combinational handling of one segment against the connection context.
`default_nettype none
module thsf_seg_logic (
  input  wire thsf_pkg::seg_t    seg,
  input  wire thsf_pkg::ctx_t    ctx,
  output thsf_pkg::upd_t    upd,
  output thsf_pkg::result_t res
);

  logic [31:0] iss_inc;
  logic [31:0] iss_fresh;
  logic [31:0] seq_inc;
  logic        bad_ack;
  logic        ack_advances;
  logic        listen_syn;

  // Wrapping initial send sequence generator.
  assign iss_inc   = ctx.iss_counter + 32'd1;
  assign iss_fresh = (iss_inc == thsf_pkg::ISS_LIMIT) ? thsf_pkg::ISS_RESTART : iss_inc;
  assign seq_inc   = seg.seq_num + 32'd1;

  assign bad_ack = seg.ack_flag &&
                   ((seg.ack_num <= ctx.local_iss) || (seg.ack_num > ctx.local_snd_nxt));
  assign ack_advances = seg.ack_flag && (seg.ack_num > ctx.send_unacked);
  assign listen_syn   = !seg.rst_flag && !seg.ack_flag && seg.syn_flag &&
                        seg.child_slot_free;

  // Next state and context updates.
  always_comb begin
    upd.conn_state   = ctx.conn_state;
    upd.iss_counter  = ctx.iss_counter;
    upd.send_unacked = ctx.send_unacked;
    case (ctx.conn_state)
      thsf_pkg::ST_LISTEN: begin
        if (listen_syn) begin
          upd.iss_counter = iss_fresh;
        end
      end
      thsf_pkg::ST_SYN_SENT: begin
        if (bad_ack) begin
          upd.conn_state = ctx.conn_state;
        end else if (seg.rst_flag && seg.ack_flag) begin
          upd.conn_state = thsf_pkg::ST_CLOSED;
        end else if (seg.syn_flag) begin
          if (ack_advances) begin
            upd.conn_state   = thsf_pkg::ST_ESTAB;
            upd.send_unacked = seg.ack_num;
          end else begin
            upd.conn_state   = thsf_pkg::ST_SYN_RCVD;
            upd.send_unacked = ctx.local_iss;
          end
        end
      end
      default: begin
        upd.conn_state = ctx.conn_state;
      end
    endcase
  end

  // Result fields.
  always_comb begin
    res.reply         = thsf_pkg::RP_NONE;
    res.wake_connect  = 1'b0;
    res.child_made    = 1'b0;
    res.child_iss     = '0;
    res.child_rcv_nxt = '0;
    case (ctx.conn_state)
      thsf_pkg::ST_LISTEN: begin
        if (seg.rst_flag) begin
          res.reply = thsf_pkg::RP_NONE;
        end else if (seg.ack_flag) begin
          res.reply = thsf_pkg::RP_RESET;
        end else if (listen_syn) begin
          res.reply         = thsf_pkg::RP_SYNACK;
          res.child_made    = 1'b1;
          res.child_iss     = iss_fresh;
          res.child_rcv_nxt = seq_inc;
        end
      end
      thsf_pkg::ST_SYN_SENT: begin
        if (bad_ack) begin
          res.reply = thsf_pkg::RP_RESET;
        end else if (seg.rst_flag && seg.ack_flag) begin
          res.wake_connect = 1'b1;
        end else if (seg.syn_flag) begin
          if (ack_advances) begin
            res.reply        = thsf_pkg::RP_ACK;
            res.wake_connect = 1'b1;
          end else begin
            res.reply = thsf_pkg::RP_SYNACK;
          end
        end
      end
      default: begin
        res.reply = thsf_pkg::RP_NONE;
      end
    endcase
    res.state_now = upd.conn_state;
  end

endmodule
`default_nettype wire

// ===== hdl/tcp_handshake_segment_fsm.sv =====
// Top level of the TCP connection-opening segment handler.
`default_nettype none
// Takes one received TCP header per transaction and runs the opening states (closed,
// listen, syn sent) on it, giving exactly one result per header. A header is accepted
// in any cycle in which the result register is empty or its result is being taken, so
// one header per cycle is sustained while results are taken; each result is registered
// and appears in the cycle after its header. That rate rests on the context update:
// state, send-unacked and the ISS counter are read and rewritten in the cycle the
// header is accepted. Configuration writes take effect at once and load the connection
// state (initial_mode), local_iss and send-unacked (local_iss) or local_snd_nxt; the
// user must make them only while no transaction is in flight, the block not enforcing it.
module tcp_handshake_segment_fsm (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // received header stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: seq_num[31:0], ack_num[63:32], window[79:64], child_slot_free[80], zero[87:81]
  input  wire logic [87:0] s_axis_tdata,
  // tuser: syn_flag[0], ack_flag[1], rst_flag[2]
  input  wire logic [2:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: state_now[2:0], wake_connect[3], child_made[4], child_iss[36:5],
  //        child_rcv_nxt[68:37], zero[71:69]
  output logic [71:0]      m_axis_tdata,
  // tuser: reply[1:0]
  output logic [1:0]       m_axis_tuser
);

  `include "tcp_handshake_segment_fsm_assert.svh"

  thsf_pkg::conn_state_t conn_state;
  logic [31:0]           iss_counter;
  logic [31:0]           send_unacked;
  logic [31:0]           local_iss;
  logic [31:0]           local_snd_nxt;

  thsf_pkg::seg_t    seg;
  thsf_pkg::ctx_t    ctx;
  thsf_pkg::upd_t    upd;
  thsf_pkg::result_t res;
  logic              in_accept;

  // Unpack the incoming transaction.
  assign seg.syn_flag        = s_axis_tuser[0];
  assign seg.ack_flag        = s_axis_tuser[1];
  assign seg.rst_flag        = s_axis_tuser[2];
  assign seg.seq_num         = s_axis_tdata[31:0];
  assign seg.ack_num         = s_axis_tdata[63:32];
  assign seg.window          = s_axis_tdata[79:64];
  assign seg.child_slot_free = s_axis_tdata[80];

  assign ctx.conn_state    = conn_state;
  assign ctx.iss_counter   = iss_counter;
  assign ctx.send_unacked  = send_unacked;
  assign ctx.local_iss     = local_iss;
  assign ctx.local_snd_nxt = local_snd_nxt;

  thsf_seg_logic u_seg_logic (
    .seg (seg),
    .ctx (ctx),
    .upd (upd),
    .res (res)
  );

  // Accept while the result register is free or draining.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Connection context and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state    <= thsf_pkg::ST_LISTEN;
      iss_counter   <= thsf_pkg::ISS_START;
      send_unacked  <= '0;
      local_iss     <= '0;
      local_snd_nxt <= thsf_pkg::LOCAL_SND_NXT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        thsf_pkg::CFG_INITIAL_MODE: begin
          conn_state <= thsf_pkg::mode_to_state(cfg_data[1:0]);
        end
        thsf_pkg::CFG_LOCAL_ISS: begin
          local_iss    <= cfg_data;
          send_unacked <= cfg_data;
        end
        thsf_pkg::CFG_LOCAL_SND_NXT: begin
          local_snd_nxt <= cfg_data;
        end
        default: begin
          local_snd_nxt <= local_snd_nxt;
        end
      endcase
    end else if (in_accept) begin
      conn_state   <= upd.conn_state;
      iss_counter  <= upd.iss_counter;
      send_unacked <= upd.send_unacked;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_axis_tdata <= {3'b000, res.child_rcv_nxt, res.child_iss, res.child_made,
                       res.wake_connect, res.state_now};
      m_axis_tuser <= res.reply;
    end
  end

  // A created child always comes with a SYN+ACK from the listening state.
  `THSF_ASSERT_NOW(a_child_synack, clk, rst, m_axis_tvalid && m_axis_tdata[4],
    (m_axis_tuser == thsf_pkg::RP_SYNACK) && (m_axis_tdata[2:0] == thsf_pkg::ST_LISTEN))

  // An ACK reply means the connection just became established and wakes the waiter.
  `THSF_ASSERT_NOW(a_ack_estab, clk, rst,
    m_axis_tvalid && (m_axis_tuser == thsf_pkg::RP_ACK),
    (m_axis_tdata[2:0] == thsf_pkg::ST_ESTAB) && m_axis_tdata[3])

  // The ISS counter stays inside its wrapping range.
  `THSF_ASSERT_NOW(a_iss_range, clk, rst, 1'b1,
    (iss_counter != thsf_pkg::ISS_LIMIT) && (iss_counter >= thsf_pkg::ISS_START))

  // An accepted header always leaves a result in the output register.
  `THSF_ASSERT_NEXT(a_accept_result, clk, rst, in_accept, m_axis_tvalid)

endmodule
`default_nettype wire
